// ----- hdl/chol_pkg.sv -----
// shared types, constants and arithmetic helpers for the cholesky factor block
package chol_pkg;

    localparam int DEF_MAX_ORDER = 8;
    localparam int Q_W           = 32;
    localparam int MAG_W         = 48;
    localparam int ROOT_W        = 24;
    localparam int SIZE_W        = 4;

    localparam logic UNIT_SQRT = 1'b0;
    localparam logic UNIT_DIV  = 1'b1;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;

    // request to the shared root / divide unit
    typedef struct packed {
        logic              start;
        logic              mode;
        logic [MAG_W-1:0]  mag;
        logic [ROOT_W-1:0] divisor;
        logic              neg;
    } unit_req_t;

    // answer from the shared root / divide unit
    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] result;
    } unit_rsp_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] x);
        logic signed [Q_W-1:0] r;
        if (x > 64'(Q_MAX))
            r = Q_MAX;
        else if (x < 64'(Q_MIN))
            r = Q_MIN;
        else
            r = x[Q_W-1:0];
        return r;
    endfunction

    // saturating add and subtract
    function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat_q(s);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat_q(s);
    endfunction

    // q16.16 product, round half up, saturated
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd32768;
        p = p >>> 16;
        return sat_q(p);
    endfunction

endpackage

// ----- hdl/chol_if.sv -----
// stream interfaces for the element input and the factor output
interface chol_in_if;
    import chol_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] a_value;
    modport source (output valid, output a_value, input ready);
    modport sink   (input valid, input a_value, output ready);
endinterface

interface chol_out_if;
    import chol_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [2:0]            row;
    logic [2:0]            col;
    logic signed [Q_W-1:0] l_value;
    logic                  not_positive;
    logic                  last;
    modport source (output valid, output row, output col, output l_value,
                    output not_positive, output last, input ready);
    modport sink   (input valid, input row, input col, input l_value,
                    input not_positive, input last, output ready);
endinterface

// ----- hdl/chol_ram.sv -----
// generic single write, single read ram with registered read data
module chol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/chol_rootdiv.sv -----
// shared iterative unit: integer square root two bits a cycle, divide one bit a cycle
module chol_rootdiv (
    input  logic                clk,
    input  logic                rst_n,
    input  chol_pkg::unit_req_t req,
    output chol_pkg::unit_rsp_t rsp
);
    import chol_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic             busy_reg;
    logic             done_reg;
    logic             mode_reg;
    logic             neg_reg;
    logic [5:0]       cnt_reg;
    logic [MAG_W-1:0] x_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] div_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [5:0]       steps;

    // one step of the shifting datapath
    always_comb
    begin
        if (mode_reg == UNIT_SQRT)
        begin
            rem_sh = {rem_reg[REM_W-3:0], x_reg[MAG_W-1 -: 2]};
            trial  = {1'b0, root_reg, 2'b01};
            steps  = 6'(MAG_W / 2 - 1);
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-2:0], x_reg[MAG_W-1]};
            trial  = {3'b000, div_reg};
            steps  = 6'(MAG_W - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                neg_reg  <= req.neg;
                div_reg  <= req.divisor;
                x_reg    <= req.mag;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (mode_reg == UNIT_SQRT)
                begin
                    x_reg <= {x_reg[MAG_W-3:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    // quotient bits shift in behind the dividend
                    if (rem_sh >= trial)
                    begin
                        rem_reg <= rem_sh - trial;
                        x_reg   <= {x_reg[MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        x_reg   <= {x_reg[MAG_W-2:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == steps)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // sign and saturation of the final answer
    always_comb
    begin
        rsp.done = done_reg;
        if (mode_reg == UNIT_SQRT)
            rsp.result = Q_W'({8'b0, root_reg});
        else if (!neg_reg)
            rsp.result = (x_reg > MAG_W'(Q_MAX)) ? Q_MAX : x_reg[Q_W-1:0];
        else if (x_reg > MAG_W'(33'h080000000))
            rsp.result = Q_MIN;
        else
            rsp.result = -x_reg[Q_W-1:0];
    end
endmodule

// ----- hdl/cholesky_factor.sv -----
// top level: load, in-place cholesky factoring sequencer and factor output
//
// Elements of an n by n symmetric matrix arrive on a_in, one beat per element,
// row-major; only the lower triangle is kept. n comes from the matrix_size
// register (cfg_we / cfg_wdata), 0 acts as 1 and values above MAX_ORDER clamp.
// Writing it restarts the element count; a_in.ready is high while loading.
// After the last beat a_in.ready drops while the sequencer factors in place:
// each product term passes S_K_RD, S_K_MUL and S_K_ACC through the one
// multiplier and saturating adder; each element then passes S_A_RD, S_A_CHK,
// a diagonal root or off-diagonal divide in the shared root / divide unit
// (divide skipped for a zero diagonal, root for a non-positive radicand,
// which sets the flag) and S_NEXT. Then the lower triangle of L streams on
// l_out in row-major order, each beat carrying row, col, the not-positive flag
// and last on the final element, each held until taken, so a stalled receiver
// simply stretches the output phase. a_in.ready returns after the last beat
// is taken. Reset sets matrix_size to min(MAX_ORDER, 8), clears the count and
// the flag; the store needs no clearing as every factoring follows a full load.
module cholesky_factor #(
    parameter int MAX_ORDER = chol_pkg::DEF_MAX_ORDER
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [chol_pkg::SIZE_W-1:0] cfg_wdata,
    chol_in_if.sink                    a_in,
    chol_out_if.source                 l_out
);
    import chol_pkg::*;

    localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CNT_W  = $clog2(MAX_ORDER + 1);
    localparam int DEF_N  = MAX_ORDER < 8 ? MAX_ORDER : 8;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_K_RD  = 4'd1;
    localparam logic [3:0] S_K_MUL = 4'd2;
    localparam logic [3:0] S_K_ACC = 4'd3;
    localparam logic [3:0] S_A_RD  = 4'd4;
    localparam logic [3:0] S_A_CHK = 4'd5;
    localparam logic [3:0] S_UNIT  = 4'd6;
    localparam logic [3:0] S_NEXT  = 4'd7;
    localparam logic [3:0] S_E_RD  = 4'd8;
    localparam logic [3:0] S_E_CAP = 4'd9;
    localparam logic [3:0] S_E_OUT = 4'd10;

    logic [3:0]        state_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  lr_reg, lc_reg;
    logic [CNT_W-1:0]  i_reg, j_reg, k_reg;
    logic              fault_reg;
    logic signed [Q_W-1:0] acc_reg;
    logic signed [Q_W-1:0] prod_reg;
    logic signed [Q_W-1:0] d_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [Q_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [Q_W-1:0]    rdata_a, rdata_b;

    logic signed [Q_W-1:0] num;
    logic [Q_W-1:0]        num_abs;
    logic [CNT_W-1:0]      n_last;
    logic [CNT_W-1:0]      cfg_n;
    unit_req_t             req;
    unit_rsp_t             rsp;

    function automatic logic [ADDR_W-1:0] addr(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_ORDER + int'(c));
    endfunction

    // two copies of the store give two read ports
    chol_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_ram_a (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(raddr_a), .rdata(rdata_a)
    );
    chol_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_ram_b (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(raddr_b), .rdata(rdata_b)
    );

    chol_rootdiv u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign n_last     = n_reg - CNT_W'(1);
    assign num        = sat_sub($signed(rdata_a), acc_reg);
    assign num_abs    = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
    assign a_in.ready = (state_reg == S_LOAD);

    // clamped order from a register write
    always_comb
    begin
        if (cfg_wdata == '0)
            cfg_n = CNT_W'(1);
        else if (int'(cfg_wdata) > MAX_ORDER)
            cfg_n = CNT_W'(MAX_ORDER);
        else
            cfg_n = CNT_W'(cfg_wdata);
    end

    // store ports and unit request
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = addr(i_reg, j_reg);
        ram_wdata   = '0;
        raddr_a     = addr(i_reg, k_reg);
        raddr_b     = addr(j_reg, k_reg);
        req.start   = 1'b0;
        req.mode    = (i_reg == j_reg) ? UNIT_SQRT : UNIT_DIV;
        req.mag     = {num_abs, 16'b0};
        req.divisor = d_reg[ROOT_W-1:0];
        req.neg     = num[Q_W-1];
        case (state_reg)
            S_LOAD:
            begin
                ram_we    = a_in.valid && (lc_reg <= lr_reg);
                ram_waddr = addr(lr_reg, lc_reg);
                ram_wdata = a_in.a_value;
            end
            S_A_RD:
            begin
                raddr_a = addr(i_reg, j_reg);
            end
            S_A_CHK:
            begin
                if (i_reg == j_reg)
                begin
                    if (num <= 0)
                        ram_we = 1'b1;
                    else
                        req.start = 1'b1;
                end
                else
                begin
                    if (d_reg == 0)
                        ram_we = 1'b1;
                    else
                        req.start = 1'b1;
                end
            end
            S_UNIT:
            begin
                ram_we    = rsp.done;
                ram_wdata = rsp.result;
            end
            S_E_RD:
            begin
                raddr_a = addr(lr_reg, lc_reg);
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            n_reg       <= CNT_W'(DEF_N);
            lr_reg      <= '0;
            lc_reg      <= '0;
            fault_reg   <= 1'b0;
            l_out.valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (cfg_we)
                    begin
                        n_reg  <= cfg_n;
                        lr_reg <= '0;
                        lc_reg <= '0;
                    end
                    else if (a_in.valid)
                    begin
                        if (lc_reg == n_last)
                        begin
                            lc_reg <= '0;
                            if (lr_reg == n_last)
                            begin
                                lr_reg    <= '0;
                                fault_reg <= 1'b0;
                                i_reg     <= '0;
                                j_reg     <= '0;
                                k_reg     <= '0;
                                acc_reg   <= '0;
                                state_reg <= S_K_RD;
                            end
                            else
                            begin
                                lr_reg <= lr_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            lc_reg <= lc_reg + CNT_W'(1);
                        end
                    end
                end
                // inner product over earlier columns
                S_K_RD:
                begin
                    state_reg <= (k_reg == j_reg) ? S_A_RD : S_K_MUL;
                end
                S_K_MUL:
                begin
                    prod_reg  <= qmul($signed(rdata_a), $signed(rdata_b));
                    state_reg <= S_K_ACC;
                end
                S_K_ACC:
                begin
                    acc_reg   <= sat_add(acc_reg, prod_reg);
                    k_reg     <= k_reg + CNT_W'(1);
                    state_reg <= S_K_RD;
                end
                S_A_RD:
                begin
                    state_reg <= S_A_CHK;
                end
                // radicand or numerator check
                S_A_CHK:
                begin
                    if (i_reg == j_reg)
                    begin
                        if (num <= 0)
                        begin
                            fault_reg <= 1'b1;
                            d_reg     <= '0;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            state_reg <= S_UNIT;
                        end
                    end
                    else
                    begin
                        state_reg <= (d_reg == 0) ? S_NEXT : S_UNIT;
                    end
                end
                S_UNIT:
                begin
                    if (rsp.done)
                    begin
                        if (i_reg == j_reg)
                            d_reg <= rsp.result;
                        state_reg <= S_NEXT;
                    end
                end
                // step to the next element of the column, then the next column
                S_NEXT:
                begin
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    state_reg <= S_K_RD;
                    if (i_reg == n_last)
                    begin
                        if (j_reg == n_last)
                        begin
                            lr_reg    <= '0;
                            lc_reg    <= '0;
                            state_reg <= S_E_RD;
                        end
                        else
                        begin
                            j_reg <= j_reg + CNT_W'(1);
                            i_reg <= j_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                // output of the factor triangle
                S_E_RD:
                begin
                    state_reg <= S_E_CAP;
                end
                S_E_CAP:
                begin
                    l_out.valid        <= 1'b1;
                    l_out.row          <= 3'(lr_reg);
                    l_out.col          <= 3'(lc_reg);
                    l_out.l_value      <= rdata_a;
                    l_out.not_positive <= fault_reg;
                    l_out.last         <= (lr_reg == n_last) && (lc_reg == lr_reg);
                    state_reg          <= S_E_OUT;
                end
                S_E_OUT:
                begin
                    if (l_out.ready)
                    begin
                        l_out.valid <= 1'b0;
                        if ((lr_reg == n_last) && (lc_reg == lr_reg))
                        begin
                            lr_reg    <= '0;
                            lc_reg    <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            if (lc_reg == lr_reg)
                            begin
                                lc_reg <= '0;
                                lr_reg <= lr_reg + CNT_W'(1);
                            end
                            else
                            begin
                                lc_reg <= lc_reg + CNT_W'(1);
                            end
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end
endmodule

// ----- tb/cholesky_factor_tb.sv -----
// testbench for the cholesky factor block: table-driven directed loads, random loads, scoreboard
`timescale 1ns / 100ps

module cholesky_factor_tb;
    import chol_pkg::*;

    localparam int ORDER_CAP   = DEF_MAX_ORDER;
    localparam int CYCLE_LIMIT = 1500000;

    // one beat of the factor output
    typedef struct packed {
        logic [2:0]            row;
        logic [2:0]            col;
        logic signed [Q_W-1:0] l_value;
        logic                  not_positive;
        logic                  last;
    } factor_beat_t;

    // one row of the directed table: size to use, matrix pattern, typed answer
    typedef enum logic [2:0] {
        PAT_IDENT, PAT_ZERO, PAT_NEG, PAT_MAX, PAT_MIN, PAT_RAND_SPD
    } pattern_e;

    typedef struct {
        logic [SIZE_W-1:0] size_code;
        pattern_e          pattern;
        logic              typed;
        logic signed [Q_W-1:0] typed_l00;
        logic              typed_np;
    } load_case_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    chol_in_if  a_in ();
    chol_out_if l_out ();

    cholesky_factor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .a_in      (a_in.sink),
        .l_out     (l_out.source)
    );

    // predictor state
    logic signed [Q_W-1:0] pred_store [ORDER_CAP*ORDER_CAP];
    int unsigned pred_order;
    int unsigned pred_count;
    factor_beat_t factor_queue [$];
    int failures;
    int cycle_count = 0;
    logic out_stall_mode = 1'b0;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [Q_W-1:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [Q_W-1:0] fx_mul(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd32768;
        return clamp32(p >>> 16);
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // factor the stored triangle and queue the expected beats
    task automatic factor_and_queue(input int unsigned n);
        logic signed [Q_W-1:0] s, r, d, t, num;
        logic signed [63:0] q;
        logic np;
        factor_beat_t b;
        np = 1'b0;
        for (int j = 0; j < n; j++)
        begin
            s = 0;
            for (int k = 0; k < j; k++)
                s = clamp32(64'(s) + 64'(fx_mul(pred_store[j*ORDER_CAP+k],
                                               pred_store[j*ORDER_CAP+k])));
            r = clamp32(64'(pred_store[j*ORDER_CAP+j]) - 64'(s));
            if (r <= 0)
            begin
                np = 1'b1;
                d = 0;
            end
            else
                d = Q_W'(int_root({32'd0, r} << 16));
            pred_store[j*ORDER_CAP+j] = d;
            for (int i = j + 1; i < n; i++)
            begin
                t = 0;
                for (int k = 0; k < j; k++)
                    t = clamp32(64'(t) + 64'(fx_mul(pred_store[i*ORDER_CAP+k],
                                                   pred_store[j*ORDER_CAP+k])));
                num = clamp32(64'(pred_store[i*ORDER_CAP+j]) - 64'(t));
                if (d == 0)
                    pred_store[i*ORDER_CAP+j] = 0;
                else
                begin
                    q = (64'(num) * 64'sd65536) / 64'(d);
                    pred_store[i*ORDER_CAP+j] = clamp32(q);
                end
            end
        end
        for (int i = 0; i < n; i++)
            for (int c = 0; c <= i; c++)
            begin
                b.row = i[2:0];
                b.col = c[2:0];
                b.l_value = pred_store[i*ORDER_CAP+c];
                b.not_positive = np;
                b.last = (i == n - 1) && (c == i);
                factor_queue.push_back(b);
            end
    endtask

    // predictor update for one accepted element
    task automatic element_taken(input logic signed [Q_W-1:0] v);
        int unsigned r, c;
        r = pred_count / pred_order;
        c = pred_count % pred_order;
        if (c <= r && r < pred_order)
            pred_store[r*ORDER_CAP+c] = v;
        pred_count++;
        if (pred_count >= pred_order * pred_order)
        begin
            pred_count = 0;
            factor_and_queue(pred_order);
        end
    endtask

    // register write while idle
    task automatic write_size(input logic [SIZE_W-1:0] code);
        int unsigned v;
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = code;
        @(negedge clk);
        cfg_we = 1'b0;
        v = code;
        if (v < 1)
            v = 1;
        if (v > ORDER_CAP)
            v = ORDER_CAP;
        pred_order = v;
        pred_count = 0;
    endtask

    // send one element, bursty sender
    task automatic send_element(input logic signed [Q_W-1:0] v);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) @(negedge clk);
        a_in.valid = 1'b1;
        a_in.a_value = v;
        @(posedge clk);
        while (!a_in.ready)
            @(posedge clk);
        element_taken(v);
        @(negedge clk);
        a_in.valid = 1'b0;
    endtask

    function automatic logic signed [Q_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
            default: return $urandom;
        endcase
    endfunction

    // element of a matrix by pattern; random spd built from a diagonal boost
    function automatic logic signed [Q_W-1:0] pattern_value(input pattern_e p,
                                                            input int r, input int c);
        case (p)
            PAT_IDENT: return (r == c) ? 32'sh00010000 : 32'sh0;
            PAT_ZERO:  return 32'sh0;
            PAT_NEG:   return (r == c) ? 32'shffff0000 : 32'sh0;
            PAT_MAX:   return 32'sh7fffffff;
            PAT_MIN:   return 32'sh80000000;
            default:
                if (r == c)
                    return $signed($urandom_range(32'h00080000, 32'h00400000));
                else
                    return $signed($urandom_range(0, 32'h00020000)) - 32'sh00010000;
        endcase
    endfunction

    // wait until nothing is expected, then some settling
    task automatic drain_results();
        while (factor_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // output checker with its own stall pattern
    always @(posedge clk)
    begin
        factor_beat_t want;
        if (rst_n && l_out.valid && l_out.ready)
        begin
            if (factor_queue.size() == 0)
            begin
                $display("%0t: unexpected beat row %0d col %0d l %h", $time,
                         l_out.row, l_out.col, l_out.l_value);
                failures++;
            end
            else
            begin
                want = factor_queue.pop_front();
                if (l_out.row !== want.row || l_out.col !== want.col
                    || l_out.l_value !== want.l_value
                    || l_out.not_positive !== want.not_positive
                    || l_out.last !== want.last)
                begin
                    $display("%0t: expected r%0d c%0d l %h np %b last %b, got r%0d c%0d l %h np %b last %b",
                             $time, want.row, want.col, want.l_value, want.not_positive,
                             want.last, l_out.row, l_out.col, l_out.l_value,
                             l_out.not_positive, l_out.last);
                    failures++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (cycle_count % 400 == 0)
            out_stall_mode <= ~out_stall_mode;
        l_out.ready <= out_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // typed rows also have the predicted first beat checked against the table
    load_case_t direct_table [12];

    initial
    begin
        logic [SIZE_W-1:0] code;
        int unsigned n;
        int sent;
        failures = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        a_in.valid = 1'b0;
        a_in.a_value = '0;
        pred_order = ORDER_CAP;
        pred_count = 0;
        foreach (pred_store[i])
            pred_store[i] = 0;

        direct_table[0]  = '{4'd1, PAT_IDENT, 1'b1, 32'sh00010000, 1'b0};
        direct_table[1]  = '{4'd1, PAT_ZERO,  1'b1, 32'sh0,        1'b1};
        direct_table[2]  = '{4'd1, PAT_NEG,   1'b1, 32'sh0,        1'b1};
        direct_table[3]  = '{4'd1, PAT_MAX,   1'b0, 32'sh0,        1'b0};
        direct_table[4]  = '{4'd1, PAT_MIN,   1'b1, 32'sh0,        1'b1};
        direct_table[5]  = '{4'd0, PAT_IDENT, 1'b1, 32'sh00010000, 1'b0};
        direct_table[6]  = '{4'd2, PAT_IDENT, 1'b1, 32'sh00010000, 1'b0};
        direct_table[7]  = '{4'd2, PAT_ZERO,  1'b1, 32'sh0,        1'b1};
        direct_table[8]  = '{4'd2, PAT_MAX,   1'b0, 32'sh0,        1'b0};
        direct_table[9]  = '{4'd3, PAT_RAND_SPD, 1'b0, 32'sh0,     1'b0};
        direct_table[10] = '{4'd15, PAT_IDENT, 1'b0, 32'sh0,       1'b0};
        direct_table[11] = '{4'd2, PAT_MIN,   1'b0, 32'sh0,        1'b0};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (direct_table[t])
        begin
            write_size(direct_table[t].size_code);
            n = pred_order;
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    send_element(pattern_value(direct_table[t].pattern, r, c));
            if (direct_table[t].typed && factor_queue.size() != 0
                && (factor_queue[0].l_value !== direct_table[t].typed_l00
                    || factor_queue[0].not_positive !== direct_table[t].typed_np))
            begin
                $display("%0t: expected l00 %h np %b, got %h np %b", $time,
                         direct_table[t].typed_l00, direct_table[t].typed_np,
                         factor_queue[0].l_value, factor_queue[0].not_positive);
                failures++;
            end
            drain_results();
        end

        // random loads, mostly small orders and mostly positive definite
        sent = 0;
        while (sent < 115)
        begin
            code = ($urandom_range(0, 9) == 0) ? 4'(ORDER_CAP) : 4'($urandom_range(1, 4));
            if ($urandom_range(0, 15) == 0)
                code = SIZE_W'($urandom);
            write_size(code);
            n = pred_order;
            // abandoned partial load now and then
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, n*n - 1 + (n == 1)))
                    if (n > 1)
                        send_element(rand_value());
                write_size(code);
            end
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_element(rand_value());
                    else
                        send_element(pattern_value(PAT_RAND_SPD, r, c));
                    sent++;
                end
            drain_results();
        end

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
